### hdl/mm4_pkg.sv
package mm4_pkg;

  localparam int DIM_DEFAULT       = 4;
  localparam int FRAC_BITS_DEFAULT = 16;
  localparam int DATA_W            = 32;

  // A finished load of both matrices, named by the buffer bank that holds it.
  typedef struct packed {
    logic valid;
    logic bank;
  } job_t;

endpackage

### hdl/matrix_multiply_4x4.sv
// Channel  Handshake             Payload
// in       in_valid / in_stall   element_value, restart
// out      out_valid / out_stall out_row, out_col, product_value, last
//
// One element is taken per cycle while in_stall is low; A and B fill one of two buffer banks.
// The back end issues one multiply-accumulate term per cycle while the output
// does not stall, DIM terms for each of the DIM*DIM elements of a product.
// Loading the next pair overlaps that work.
// Reset clears the load position, bank flags and queue; no clearing pass.
// A stall on the output freezes the back end; the input stalls only while
// the bank it would fill is still being read.
module matrix_multiply_4x4 #(
  parameter int DIM       = mm4_pkg::DIM_DEFAULT,
  parameter int FRAC_BITS = mm4_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [mm4_pkg::DATA_W-1:0]  element_value,
  input  logic                        restart,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [$clog2(DIM)-1:0]      out_row,
  output logic [$clog2(DIM)-1:0]      out_col,
  output logic [mm4_pkg::DATA_W-1:0]  product_value,
  output logic                        last
);

  import mm4_pkg::*;

  localparam int CELLS  = DIM * DIM;
  localparam int ADDR_W = $clog2(2 * CELLS);
  localparam int IDX_W  = $clog2(DIM);

  job_t              push_job;
  job_t              release_job;
  job_t              head;
  logic              pop;
  logic              left_wr_en;
  logic              right_wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] left_rd_addr;
  logic [ADDR_W-1:0] right_rd_addr;
  logic [DATA_W-1:0] left_rd_data;
  logic [DATA_W-1:0] right_rd_data;

  mm4_front #(
    .DIM (DIM)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .element_value (element_value),
    .restart       (restart),
    .release_job   (release_job),
    .push_job      (push_job),
    .left_wr_en    (left_wr_en),
    .right_wr_en   (right_wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data)
  );

  mm4_ram #(
    .WIDTH (DATA_W),
    .DEPTH (2 * CELLS)
  ) u_left_ram (
    .clk     (clk),
    .wr_en   (left_wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (left_rd_addr),
    .rd_data (left_rd_data)
  );

  mm4_ram #(
    .WIDTH (DATA_W),
    .DEPTH (2 * CELLS)
  ) u_right_ram (
    .clk     (clk),
    .wr_en   (right_wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (right_rd_addr),
    .rd_data (right_rd_data)
  );

  mm4_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push_job (push_job),
    .pop      (pop),
    .head     (head)
  );

  mm4_back #(
    .DIM       (DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .pop           (pop),
    .release_job   (release_job),
    .rd_en         (rd_en),
    .left_rd_addr  (left_rd_addr),
    .right_rd_addr (right_rd_addr),
    .left_rd_data  (left_rd_data),
    .right_rd_data (right_rd_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_row       (out_row),
    .out_col       (out_col),
    .product_value (product_value),
    .last          (last)
  );

  // A finished load must never land in the bank that is being multiplied.
  assert property (@(posedge clk) disable iff (rst)
    (push_job.valid && head.valid) |-> (push_job.bank != head.bank))
    else $error("load completed into a bank still in use");

  // The back end can only finish the job at the head of the queue.
  assert property (@(posedge clk) disable iff (rst)
    release_job.valid |-> head.valid)
    else $error("job released with an empty queue");

  // The final marker belongs to the bottom-right element alone.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (out_row == IDX_W'(DIM - 1)) && (out_col == IDX_W'(DIM - 1)))
    else $error("last marker on the wrong element");

  // An element is complete only after DIM terms, so results cannot come back to back
  // with a job start: after a result is taken, out_valid drops before another follows.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> !out_valid)
    else $error("results delivered in consecutive cycles");

endmodule

### hdl/mm4_ram.sv
module mm4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/mm4_front.sv
module mm4_front #(
  parameter int DIM = mm4_pkg::DIM_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [mm4_pkg::DATA_W-1:0]            element_value,
  input  logic                                  restart,
  input  mm4_pkg::job_t                         release_job,
  output mm4_pkg::job_t                         push_job,
  output logic                                  left_wr_en,
  output logic                                  right_wr_en,
  output logic [$clog2(2*DIM*DIM)-1:0]          wr_addr,
  output logic [mm4_pkg::DATA_W-1:0]            wr_data
);

  import mm4_pkg::*;

  localparam int CELLS  = DIM * DIM;
  localparam int ADDR_W = $clog2(2 * CELLS);

  logic [ADDR_W-1:0] load_position;
  logic [ADDR_W-1:0] load_position_next;
  logic              bank;
  logic [1:0]        busy;
  logic [1:0]        busy_next;
  logic [ADDR_W-1:0] slot;
  logic [ADDR_W-1:0] bank_off;
  logic              take;
  logic              final_slot;

  // The bank being filled must not still be read by the back end.
  assign in_stall   = busy[bank];
  assign take       = in_valid && !in_stall;
  assign slot       = restart ? '0 : load_position;
  assign final_slot = (slot == ADDR_W'(2 * CELLS - 1));
  assign bank_off   = bank ? ADDR_W'(CELLS) : '0;

  always_comb begin
    left_wr_en  = take && (slot < ADDR_W'(CELLS));
    right_wr_en = take && (slot >= ADDR_W'(CELLS));
    wr_data     = element_value;
    if (slot < ADDR_W'(CELLS)) begin
      wr_addr = bank_off + slot;
    end else begin
      wr_addr = bank_off + slot - ADDR_W'(CELLS);
    end
    push_job.valid = take && final_slot;
    push_job.bank  = bank;

    load_position_next = load_position;
    if (take) begin
      load_position_next = final_slot ? '0 : slot + ADDR_W'(1);
    end

    busy_next = busy;
    if (release_job.valid) begin
      busy_next[release_job.bank] = 1'b0;
    end
    if (push_job.valid) begin
      busy_next[bank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_position <= '0;
      bank          <= 1'b0;
      busy          <= '0;
    end else begin
      load_position <= load_position_next;
      busy          <= busy_next;
      if (push_job.valid) begin
        bank <= !bank;
      end
    end
  end

endmodule

### hdl/mm4_queue.sv
module mm4_queue (
  input  logic          clk,
  input  logic          rst,
  input  mm4_pkg::job_t push_job,
  input  logic          pop,
  output mm4_pkg::job_t head
);

  import mm4_pkg::*;

  logic       entry [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic [1:0] count_next;

  assign head.valid = (count != 2'd0);
  assign head.bank  = entry[rd_ptr];

  always_comb begin
    count_next = count;
    case ({push_job.valid, pop})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push_job.valid) begin
      entry[wr_ptr] <= push_job.bank;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (push_job.valid) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

endmodule

### hdl/mm4_back.sv
module mm4_back #(
  parameter int DIM       = mm4_pkg::DIM_DEFAULT,
  parameter int FRAC_BITS = mm4_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  mm4_pkg::job_t                  head,
  output logic                           pop,
  output mm4_pkg::job_t                  release_job,
  output logic                           rd_en,
  output logic [$clog2(2*DIM*DIM)-1:0]   left_rd_addr,
  output logic [$clog2(2*DIM*DIM)-1:0]   right_rd_addr,
  input  logic [mm4_pkg::DATA_W-1:0]     left_rd_data,
  input  logic [mm4_pkg::DATA_W-1:0]     right_rd_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [$clog2(DIM)-1:0]         out_row,
  output logic [$clog2(DIM)-1:0]         out_col,
  output logic [mm4_pkg::DATA_W-1:0]     product_value,
  output logic                           last
);

  import mm4_pkg::*;

  localparam int CELLS  = DIM * DIM;
  localparam int ADDR_W = $clog2(2 * CELLS);
  localparam int IDX_W  = $clog2(DIM);
  localparam int PROD_W = 2 * DATA_W;

  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(DIM - 1);

  logic              en;
  logic              issue;
  logic              final_term;
  logic [IDX_W-1:0]  row;
  logic [IDX_W-1:0]  col;
  logic [IDX_W-1:0]  term;
  logic [ADDR_W-1:0] bank_off;

  logic              s1_valid;
  logic              s1_first;
  logic              s1_end;
  logic              s1_last;
  logic [IDX_W-1:0]  s1_row;
  logic [IDX_W-1:0]  s1_col;

  logic              s2_valid;
  logic              s2_first;
  logic              s2_end;
  logic              s2_last;
  logic [IDX_W-1:0]  s2_row;
  logic [IDX_W-1:0]  s2_col;
  logic signed [PROD_W-1:0] s2_prod;

  logic [DATA_W-1:0]        acc;
  logic [DATA_W-1:0]        base;
  logic signed [PROD_W-1:0] shifted;
  logic [PROD_W:0]          sum;
  logic [DATA_W-1:0]        sat;

  // The whole pipeline freezes while a result waits at the output.
  assign en         = !out_valid || !out_stall;
  assign issue      = en && head.valid;
  assign final_term = (term == IDX_MAX) && (col == IDX_MAX) && (row == IDX_MAX);
  assign pop        = issue && final_term;
  assign release_job.valid = pop;
  assign release_job.bank  = head.bank;
  assign rd_en      = en;
  assign bank_off   = head.bank ? ADDR_W'(CELLS) : '0;

  assign left_rd_addr  = bank_off + ADDR_W'(row) * ADDR_W'(DIM) + ADDR_W'(term);
  assign right_rd_addr = bank_off + ADDR_W'(term) * ADDR_W'(DIM) + ADDR_W'(col);

  // Floor shift of the full product, then a saturating add onto the sum.
  always_comb begin
    base    = s2_first ? '0 : acc;
    shifted = s2_prod >>> FRAC_BITS;
    sum     = {{(DATA_W + 1){base[DATA_W-1]}}, base} + {shifted[PROD_W-1], shifted};
    if ((sum[PROD_W:DATA_W-1] == '0) || (sum[PROD_W:DATA_W-1] == '1)) begin
      sat = sum[DATA_W-1:0];
    end else if (sum[PROD_W]) begin
      sat = {1'b1, {(DATA_W - 1){1'b0}}};
    end else begin
      sat = {1'b0, {(DATA_W - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row      <= '0;
      col      <= '0;
      term     <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      if (issue) begin
        if (term == IDX_MAX) begin
          term <= '0;
          if (col == IDX_MAX) begin
            col <= '0;
            row <= (row == IDX_MAX) ? '0 : row + IDX_W'(1);
          end else begin
            col <= col + IDX_W'(1);
          end
        end else begin
          term <= term + IDX_W'(1);
        end
      end
      s1_valid  <= issue;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid && s2_end;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_first <= (term == '0);
      s1_end   <= (term == IDX_MAX);
      s1_last  <= (row == IDX_MAX) && (col == IDX_MAX);
      s1_row   <= row;
      s1_col   <= col;

      s2_first <= s1_first;
      s2_end   <= s1_end;
      s2_last  <= s1_last;
      s2_row   <= s1_row;
      s2_col   <= s1_col;
      s2_prod  <= $signed(left_rd_data) * $signed(right_rd_data);

      if (s2_valid) begin
        acc <= sat;
      end
      if (s2_valid && s2_end) begin
        product_value <= sat;
        out_row       <= s2_row;
        out_col       <= s2_col;
        last          <= s2_last;
      end
    end
  end

endmodule
